### src/symmetric_fir_decimator_by_ten_macros.svh
// Assertion macros for the symmetric FIR decimator.
// Used by the top level only; expects clk and rst in scope.
`ifndef SYMMETRIC_FIR_DECIMATOR_BY_TEN_MACROS_SVH
`define SYMMETRIC_FIR_DECIMATOR_BY_TEN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sfd_pkg.sv
// Shared constants, types and coefficient ROM of the symmetric FIR decimator.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package sfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int HALF_TAPS   = 130;
  localparam int DECIMATION  = 10;
  localparam int NUM_TAPS    = 2 * HALF_TAPS;
  localparam int ROM_SIZE    = 130;

  localparam int COEF_BITS = 32;
  localparam int COEF_FRAC = 31;
  localparam int ACC_BITS  = 64;
  localparam int PAIR_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = PAIR_BITS + COEF_BITS;

  localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int ADDR_BITS  = $clog2(NUM_TAPS);
  localparam int FILL_BITS  = $clog2(NUM_TAPS + 1);
  localparam int TAP_BITS   = $clog2(HALF_TAPS + 1);
  localparam int PHASE_BITS = $clog2(DECIMATION + 1);

  localparam int ROM_SIZE_BITS = $clog2(ROM_SIZE);
  localparam int ROM_IDX_BITS  = (TAP_BITS > ROM_SIZE_BITS) ? TAP_BITS : ROM_SIZE_BITS;
  localparam int ROM_DEPTH     = 2 ** ROM_IDX_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef coef_t                         coef_rom_t [ROM_DEPTH];

  // One tap pair issued by the sequencer to the MAC
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic                lo_ok;
    logic                hi_ok;
    logic [TAP_BITS-1:0] tap;
  } tap_req_t;

  typedef struct packed {
    logic    valid;
    sample_t value;
  } mac_result_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } seq_state_t;

  // Decimal coefficients: value = mant * 10^-(8 + exp)
  localparam int ROM_MANT [ROM_SIZE] = '{
    -221394475, -384535815, -437853414, -733722990, -914422270,
    -123938036, -149931453, -182887350, -209853868, -237086758,
    -256050523, -269085954, -270466349, -260901754, -237020460,
    -199575967, -147611397, -830789066, -754570009,  752988052,
     161596254,  246079027,  323379936,  387565407,  433107110,
     454859517,  448835693,  412364374,  344629923,  246817391,
     122360550, -231280355, -181951138, -344674597, -500592286,
    -638365628, -746739503, -815366219, -835626851, -801409710,
    -709796207, -561590364, -361609301, -118741082,  154299850,
     441516895,  724451324,  983254634,  119797245,  134993438,
     142317742,  140583271,  129129179,  107914617,  775740248,
     394305388, -453973334, -517899868, -993356573, -143926206,
    -182251318, -211168220, -227933633, -230428576, -217355182,
    -188391749, -144292321, -869178445, -191919025,  550195341,
     131105061,  203971169,  268357107,  319189206,  351942912,
     362999248,  349960895,  311909197,  249577942,  165425078,
     635925447, -502531242, -169196655, -285453256, -390836782,
    -477287639, -537430168, -565125141, -555977458, -507763680,
    -420745555, -297838403, -144616992,  308558868,  218377239,
     406116107,  581273483,  730846961,  842472258,  905277486,
     910711288,  853281188,  731155462,  546582648,  306090363,
     204397496, -295675639, -624184543, -944424327, -123412758,
    -147055937, -163174812, -169774238, -165182277, -148159964,
    -117992693, -745576526, -183624704,  494480971,  127118798,
     212343372,  302354842,  394042134,  484087914,  569119937,
     645869150,  711325034,  762880817,  798460468,  816620364
  };

  localparam int ROM_EXP [ROM_SIZE] = '{
    5, 5, 5, 5, 5,  4, 4, 4, 4, 4,
    4, 4, 4, 4, 4,  4, 4, 5, 6, 5,
    4, 4, 4, 4, 4,  4, 4, 4, 4, 4,
    4, 5, 4, 4, 4,  4, 4, 4, 4, 4,
    4, 4, 4, 4, 4,  4, 4, 4, 3, 3,
    3, 3, 3, 3, 4,  4, 5, 4, 4, 3,
    3, 3, 3, 3, 3,  3, 3, 4, 4, 4,
    3, 3, 3, 3, 3,  3, 3, 3, 3, 3,
    4, 4, 3, 3, 3,  3, 3, 3, 3, 3,
    3, 3, 3, 4, 3,  3, 3, 3, 3, 3,
    3, 3, 3, 3, 3,  4, 3, 3, 3, 2,
    2, 2, 2, 2, 2,  2, 3, 3, 3, 2,
    2, 2, 2, 2, 2,  2, 2, 2, 2, 2
  };

  // Round to Q0.31, half away from zero; entries past the source list are zero
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t   rom;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    int          k;
    for (k = 0; k < ROM_DEPTH; k++) begin
      rom[k] = '0;
      if (k < ROM_SIZE) begin
        neg = (ROM_MANT[k] < 0);
        mag = neg ? 64'(-ROM_MANT[k]) : 64'(ROM_MANT[k]);
        case (ROM_EXP[k])
          2:       q = ((mag << 31) + 64'd5000000000) / 64'd10000000000;
          3:       q = ((mag << 31) + 64'd50000000000) / 64'd100000000000;
          4:       q = ((mag << 31) + 64'd500000000000) / 64'd1000000000000;
          5:       q = ((mag << 31) + 64'd5000000000000) / 64'd10000000000000;
          6:       q = ((mag << 31) + 64'd50000000000000) / 64'd100000000000000;
          default: q = '0;
        endcase
        rom[k] = neg ? -COEF_BITS'(q) : COEF_BITS'(q);
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_coef_rom();

endpackage

`default_nettype wire

### src/sfd_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Holds the sample history; no package dependency.
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 260
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

### src/sfd_ctrl.sv
// Sequencer: circular write pointer, fill count, decimation phase and the
// walk over tap pairs. Depends on sfd_pkg.
`default_nettype none

module sfd_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            out_busy,
  input  wire logic                            done,
  output logic                                 ready,
  output logic                                 wr_en,
  output logic [sfd_pkg::ADDR_BITS-1:0]        wr_addr,
  output logic [sfd_pkg::ADDR_BITS-1:0]        rd_addr_lo,
  output logic [sfd_pkg::ADDR_BITS-1:0]        rd_addr_hi,
  output sfd_pkg::tap_req_t                    tap_req
);

  localparam int AB  = sfd_pkg::ADDR_BITS;
  localparam int FB  = sfd_pkg::FILL_BITS;
  localparam int TB  = sfd_pkg::TAP_BITS;
  localparam int PHB = sfd_pkg::PHASE_BITS;

  sfd_pkg::seq_state_t state;
  logic [AB-1:0]       wr_ptr;
  logic [FB-1:0]       fill;
  logic [PHB-1:0]      phase;
  logic [TB-1:0]       tap;
  logic [AB-1:0]       lo_addr;
  logic [AB-1:0]       hi_addr;
  logic                accept;
  logic                phase_last;
  logic                tap_last;

  function automatic logic [AB-1:0] addr_inc(input logic [AB-1:0] a);
    return (a == AB'(sfd_pkg::NUM_TAPS - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AB-1:0] addr_dec(input logic [AB-1:0] a);
    return (a == '0) ? AB'(sfd_pkg::NUM_TAPS - 1) : a - 1'b1;
  endfunction

  assign phase_last = (phase == PHB'(sfd_pkg::DECIMATION - 1));
  assign tap_last   = (tap == TB'(sfd_pkg::HALF_TAPS - 1));

  // Hold off a sample that would start a sum while the last result is still unread
  assign ready  = (state == sfd_pkg::ST_IDLE) && !(phase_last && out_busy);
  assign accept = in_valid && ready;

  assign wr_en      = accept;
  assign wr_addr    = wr_ptr;
  assign rd_addr_lo = lo_addr;
  assign rd_addr_hi = hi_addr;

  // An entry older than the fill count was never written and reads as zero
  always_comb begin
    tap_req.valid = (state == sfd_pkg::ST_RUN);
    tap_req.first = (tap == '0);
    tap_req.last  = tap_last;
    tap_req.hi_ok = (FB'(tap) < fill);
    tap_req.lo_ok = ((FB'(sfd_pkg::NUM_TAPS - 1) - FB'(tap)) < fill);
    tap_req.tap   = tap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sfd_pkg::ST_IDLE;
      wr_ptr  <= '0;
      fill    <= '0;
      phase   <= '0;
      tap     <= '0;
      lo_addr <= '0;
      hi_addr <= '0;
    end else begin
      case (state)
        sfd_pkg::ST_IDLE: begin
          if (accept) begin
            wr_ptr <= addr_inc(wr_ptr);
            if (fill != FB'(sfd_pkg::NUM_TAPS)) begin
              fill <= fill + 1'b1;
            end
            if (phase_last) begin
              // oldest sits just past the new sample, newest at it
              phase   <= '0;
              tap     <= '0;
              lo_addr <= addr_inc(wr_ptr);
              hi_addr <= wr_ptr;
              state   <= sfd_pkg::ST_RUN;
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        sfd_pkg::ST_RUN: begin
          lo_addr <= addr_inc(lo_addr);
          hi_addr <= addr_dec(hi_addr);
          tap     <= tap + 1'b1;
          if (tap_last) begin
            state <= sfd_pkg::ST_DRAIN;
          end
        end
        sfd_pkg::ST_DRAIN: begin
          if (done) begin
            state <= sfd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= sfd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sfd_mac.sv
// Pre-add multiply-accumulate pipeline with coefficient ROM, followed by
// the shift, truncation toward zero and saturation. Depends on sfd_pkg.
`default_nettype none

module sfd_mac (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfd_pkg::tap_req_t   tap_req,
  input  wire sfd_pkg::sample_t    lo_data,
  input  wire sfd_pkg::sample_t    hi_data,
  output sfd_pkg::mac_result_t     result
);

  localparam int SB  = sfd_pkg::SAMPLE_BITS;
  localparam int PB  = sfd_pkg::PAIR_BITS;
  localparam int PRB = sfd_pkg::PROD_BITS;
  localparam int ACB = sfd_pkg::ACC_BITS;
  localparam int RIB = sfd_pkg::ROM_IDX_BITS;
  localparam int QB  = sfd_pkg::ACC_BITS - sfd_pkg::COEF_FRAC;
  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (SB - 1));

  // stage 1: aligned with the RAM read data
  sfd_pkg::tap_req_t       s1;
  sfd_pkg::coef_t          coef1;
  logic signed [PB-1:0]    lo_ext;
  logic signed [PB-1:0]    hi_ext;
  logic signed [PB-1:0]    pair;
  // stage 2: pre-added pair
  logic                    v2, first2, last2;
  logic signed [PB-1:0]    pair2;
  sfd_pkg::coef_t          coef2;
  // stage 3: product
  logic                    v3, first3, last3;
  logic signed [PRB-1:0]   prod3;
  // stage 4: accumulator
  logic [ACB-1:0]          acc;
  logic                    done4;
  // output conversion
  logic                    neg;
  logic [ACB-1:0]          mag;
  logic [QB-1:0]           q;
  logic [QB-1:0]           q_sat;
  logic [SB-1:0]           sat_value;

  always_comb begin
    lo_ext = s1.lo_ok ? PB'(lo_data) : '0;
    hi_ext = s1.hi_ok ? PB'(hi_data) : '0;
    pair   = lo_ext + hi_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      done4    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      s1.valid     <= tap_req.valid;
      v2           <= s1.valid;
      v3           <= v2;
      done4        <= v3 && last3;
      result.valid <= done4;
    end

    s1.first <= tap_req.first;
    s1.last  <= tap_req.last;
    s1.lo_ok <= tap_req.lo_ok;
    s1.hi_ok <= tap_req.hi_ok;
    s1.tap   <= tap_req.tap;
    coef1    <= sfd_pkg::COEF_ROM[RIB'(tap_req.tap)];

    first2 <= s1.first;
    last2  <= s1.last;
    pair2  <= pair;
    coef2  <= coef1;

    first3 <= first2;
    last3  <= last2;
    prod3  <= pair2 * coef2;

    // restart on the first pair of a sum; wraps modulo the accumulator width
    if (v3) begin
      acc <= (first3 ? '0 : acc) + ACB'(prod3);
    end

    result.value <= sat_value;
  end

  // Shift by the fraction bits with truncation toward zero, then saturate
  always_comb begin
    neg = acc[ACB-1];
    mag = neg ? (~acc + 1'b1) : acc;
    q   = mag[ACB-1:sfd_pkg::COEF_FRAC];
    if (neg) begin
      q_sat     = (q > LIM_NEG) ? LIM_NEG : q;
      sat_value = -q_sat[SB-1:0];
    end else begin
      q_sat     = (q > LIM_POS) ? LIM_POS : q;
      sat_value = q_sat[SB-1:0];
    end
  end

endmodule

`default_nettype wire

### src/symmetric_fir_decimator_by_ten.sv
// Symmetric 260-tap FIR low-pass filter with decimation by ten. Each sample
// beat is written into a circular sample RAM; every tenth sample starts a
// sum in which one pre-add multiply-accumulate unit reads two RAM entries
// per cycle (one from each end of the history) and takes one of the 130
// coefficient pairs each cycle, then the pipeline drains. The input is held
// off while a sum is running. The sample history reads as zero until it has
// been filled after reset (no clearing pass). Outputs are truncated toward
// zero and saturated to the 24-bit sample range.
// Depends on sfd_pkg, sfd_ram, sfd_ctrl and sfd_mac.
`default_nettype none

`include "symmetric_fir_decimator_by_ten_macros.svh"

module symmetric_fir_decimator_by_ten (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [sfd_pkg::TDATA_BITS-1:0]   s_axis_tdata,  // [23:0] sample
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [sfd_pkg::TDATA_BITS-1:0]   m_axis_tdata   // [23:0] filtered
);

  localparam int SB = sfd_pkg::SAMPLE_BITS;
  localparam int AB = sfd_pkg::ADDR_BITS;
  localparam int TD = sfd_pkg::TDATA_BITS;

  logic                 wr_en;
  logic [AB-1:0]        wr_addr;
  logic [AB-1:0]        rd_addr_lo;
  logic [AB-1:0]        rd_addr_hi;
  logic [SB-1:0]        lo_word;
  logic [SB-1:0]        hi_word;
  sfd_pkg::tap_req_t    tap_req;
  sfd_pkg::mac_result_t mac_result;
  logic [SB-1:0]        out_data;

  sfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .out_busy   (m_axis_tvalid),
    .done       (mac_result.valid),
    .ready      (s_axis_tready),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr_lo (rd_addr_lo),
    .rd_addr_hi (rd_addr_hi),
    .tap_req    (tap_req)
  );

  sfd_ram #(
    .WIDTH (SB),
    .DEPTH (sfd_pkg::NUM_TAPS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (s_axis_tdata[SB-1:0]),
    .rd_addr_a (rd_addr_lo),
    .rd_addr_b (rd_addr_hi),
    .rd_data_a (lo_word),
    .rd_data_b (hi_word)
  );

  sfd_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .tap_req (tap_req),
    .lo_data (sfd_pkg::sample_t'(lo_word)),
    .hi_data (sfd_pkg::sample_t'(hi_word)),
    .result  (mac_result)
  );

  // Output register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (mac_result.valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_result.valid) begin
      out_data <= mac_result.value;
    end
  end

  assign m_axis_tdata = TD'(out_data);

  `SFD_ASSERT_SAME(a_result_into_free_reg, mac_result.valid, !m_axis_tvalid, "result while output register full")
  `SFD_ASSERT_NEXT(a_result_presented, mac_result.valid, m_axis_tvalid, "finished result not presented")
  `SFD_ASSERT_SAME(a_no_sample_during_sum, tap_req.valid, !s_axis_tready, "sample taken during a sum")
  `SFD_ASSERT_NEXT(a_sum_ends_after_last, tap_req.valid && tap_req.last, !tap_req.valid, "tap walk ran past the last pair")

endmodule

`default_nettype wire

### tb/symmetric_fir_decimator_by_ten_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the symmetric 260-tap FIR decimator by ten.
// Needs only sfd_pkg (sample type, tdata width) and the top-level RTL.

module symmetric_fir_decimator_by_ten_tb;

  typedef sfd_pkg::sample_t sample_t;

  localparam int HALF_LEN    = 130;
  localparam int LINE_LEN    = 2 * HALF_LEN;
  localparam int RATIO       = 10;
  localparam int RANDOM_BEATS = 1500;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 300;

  localparam sample_t MAX_SAMPLE = 24'sh7FFFFF;
  localparam sample_t MIN_SAMPLE = 24'sh800000;

  // Decimal coefficients: value = mantissa * 10^-(8 + exponent)
  localparam int TAP_MANT [HALF_LEN] = '{
    -221394475, -384535815, -437853414, -733722990, -914422270,
    -123938036, -149931453, -182887350, -209853868, -237086758,
    -256050523, -269085954, -270466349, -260901754, -237020460,
    -199575967, -147611397, -830789066, -754570009,  752988052,
     161596254,  246079027,  323379936,  387565407,  433107110,
     454859517,  448835693,  412364374,  344629923,  246817391,
     122360550, -231280355, -181951138, -344674597, -500592286,
    -638365628, -746739503, -815366219, -835626851, -801409710,
    -709796207, -561590364, -361609301, -118741082,  154299850,
     441516895,  724451324,  983254634,  119797245,  134993438,
     142317742,  140583271,  129129179,  107914617,  775740248,
     394305388, -453973334, -517899868, -993356573, -143926206,
    -182251318, -211168220, -227933633, -230428576, -217355182,
    -188391749, -144292321, -869178445, -191919025,  550195341,
     131105061,  203971169,  268357107,  319189206,  351942912,
     362999248,  349960895,  311909197,  249577942,  165425078,
     635925447, -502531242, -169196655, -285453256, -390836782,
    -477287639, -537430168, -565125141, -555977458, -507763680,
    -420745555, -297838403, -144616992,  308558868,  218377239,
     406116107,  581273483,  730846961,  842472258,  905277486,
     910711288,  853281188,  731155462,  546582648,  306090363,
     204397496, -295675639, -624184543, -944424327, -123412758,
    -147055937, -163174812, -169774238, -165182277, -148159964,
    -117992693, -745576526, -183624704,  494480971,  127118798,
     212343372,  302354842,  394042134,  484087914,  569119937,
     645869150,  711325034,  762880817,  798460468,  816620364
  };

  localparam int TAP_EXP [HALF_LEN] = '{
    5, 5, 5, 5, 5,  4, 4, 4, 4, 4,
    4, 4, 4, 4, 4,  4, 4, 5, 6, 5,
    4, 4, 4, 4, 4,  4, 4, 4, 4, 4,
    4, 5, 4, 4, 4,  4, 4, 4, 4, 4,
    4, 4, 4, 4, 4,  4, 4, 4, 3, 3,
    3, 3, 3, 3, 4,  4, 5, 4, 4, 3,
    3, 3, 3, 3, 3,  3, 3, 4, 4, 4,
    3, 3, 3, 3, 3,  3, 3, 3, 3, 3,
    4, 4, 3, 3, 3,  3, 3, 3, 3, 3,
    3, 3, 3, 4, 3,  3, 3, 3, 3, 3,
    3, 3, 3, 3, 3,  4, 3, 3, 3, 2,
    2, 2, 2, 2, 2,  2, 3, 3, 3, 2,
    2, 2, 2, 2, 2,  2, 2, 2, 2, 2
  };

  localparam sample_t DIRECTED [25] = '{
    24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'shFFFFFF,
    24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
    24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
    24'sh400000, 24'shC00000, 24'sh000000, 24'shFFFFFF, 24'sh000001,
    24'sh123456, 24'shEDCBA9, 24'sh7FFFFF, 24'sh800000, 24'sh000000
  };

  // Filter model and queue of outputs still owed by the block
  class fir_scoreboard;
    int      coef [HALF_LEN];
    sample_t history [LINE_LEN];
    int      phase;
    sample_t outputs_due [$];
    int      samples_in;
    int      outputs_checked;
    int      saturations;
    int      errors;

    function new();
      longint unsigned mag, div, q;
      bit neg;
      int k, j;
      for (k = 0; k < HALF_LEN; k++) begin
        neg = TAP_MANT[k] < 0;
        mag = neg ? -longint'(TAP_MANT[k]) : longint'(TAP_MANT[k]);
        div = 1;
        for (j = 0; j < 8 + TAP_EXP[k]; j++) div = div * 10;
        // round half away from zero on the magnitude
        q = ((mag << 31) + div / 2) / div;
        coef[k] = neg ? -int'(q) : int'(q);
      end
      for (k = 0; k < LINE_LEN; k++) history[k] = '0;
      phase = 0;
      samples_in = 0;
      outputs_checked = 0;
      saturations = 0;
      errors = 0;
    endfunction

    function void note_sample(sample_t s);
      longint acc, pair;
      longint unsigned mag, q;
      bit neg;
      sample_t filtered;
      int i;
      for (i = 0; i < LINE_LEN - 1; i++) history[i] = history[i + 1];
      history[LINE_LEN - 1] = s;
      samples_in++;
      phase++;
      if (phase < RATIO) return;
      phase = 0;
      acc = 0;
      for (i = 0; i < HALF_LEN; i++) begin
        pair = longint'(history[i]) + longint'(history[LINE_LEN - 1 - i]);
        acc = acc + pair * longint'(coef[i]);
      end
      // truncate toward zero, then clamp to the sample range
      neg = acc[63];
      mag = acc;
      if (neg) mag = -mag;
      q = mag >> 31;
      if (neg) begin
        if (q > 64'h80_0000) begin
          q = 64'h80_0000;
          saturations++;
        end
        filtered = sample_t'(64'd0 - q);
      end else begin
        if (q > 64'h7F_FFFF) begin
          q = 64'h7F_FFFF;
          saturations++;
        end
        filtered = sample_t'(q);
      end
      outputs_due.push_back(filtered);
    endfunction

    task report(string line);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $time, line);
      errors++;
    endtask

    task check_filtered(sample_t got);
      sample_t want;
      if (outputs_due.size() == 0) begin
        report($sformatf("unexpected output %0d", got));
      end else begin
        want = outputs_due.pop_front();
        outputs_checked++;
        if (got !== want)
          report($sformatf("output %0d: filtered got %0d, want %0d",
                           outputs_checked, got, want));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [sfd_pkg::TDATA_BITS-1:0]   s_axis_tdata;   // [23:0] sample
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [sfd_pkg::TDATA_BITS-1:0]   m_axis_tdata;   // [23:0] filtered

  fir_scoreboard sb;
  int beats_sent;
  int burst_left;
  int rx_mode;
  int rx_cycle;

  symmetric_fir_decimator_by_ten i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  // Sample both handshakes on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[23:0]);
      if (m_axis_tvalid && m_axis_tready) sb.check_filtered(m_axis_tdata[23:0]);
    end
  end

  // Output sink: the stall pattern switches among four modes, picked at random
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cycle <= 0;
      rx_mode <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          m_axis_tready <= (rx_cycle % 16) < 5;
        end
      endcase
    end
  end

  task idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= sample_t'($urandom);
    end
  endtask

  // Hold the beat until accepted; before a new burst, insert a random gap with probability 3/4
  task send_sample(sample_t s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 50);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  initial begin
    int      k, kind, run, val;
    bit      flip;
    sample_t s;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    beats_sent = 0;
    burst_left = 0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes and bit patterns, including the silent start-up samples
    for (k = 0; k < 25; k++) send_sample(DIRECTED[k]);

    while (beats_sent < 25 + RANDOM_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        run = $urandom_range(5, 60);
        repeat (run) send_sample(sample_t'($urandom));
      end else if (kind < 55) begin
        run = $urandom_range(5, 40);
        repeat (run) begin
          case ($urandom_range(0, 4))
            0: s = MAX_SAMPLE;
            1: s = MIN_SAMPLE;
            2: s = '0;
            3: s = 24'shFFFFFF;
            default: s = 24'sh000001;
          endcase
          send_sample(s);
        end
      end else if (kind < 70) begin
        run = $urandom_range(5, 60);
        repeat (run) begin
          val = int'($urandom_range(0, 1023)) - 512;
          send_sample(sample_t'(val));
        end
      end else if (kind < 82) begin
        // steady level long enough to fill the whole history
        s = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) == 1) ? MAX_SAMPLE
                                                                       : MIN_SAMPLE)
                                        : sample_t'($urandom);
        run = $urandom_range(LINE_LEN, LINE_LEN + 40);
        repeat (run) send_sample(s);
      end else begin
        // align to an output, then fill the history with coefficient signs to saturate
        while (beats_sent % RATIO != 0) send_sample(sample_t'($urandom));
        flip = $urandom_range(0, 1);
        for (k = 0; k < LINE_LEN; k++) begin
          val = 8388607 - int'($urandom_range(0, 4095));
          if ((sb.coef[(k < HALF_LEN) ? k : LINE_LEN - 1 - k] < 0) ^ flip) val = -val;
          send_sample(sample_t'(val));
        end
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples and %0d decimated outputs, %0d of them saturated.",
             sb.samples_in, sb.outputs_checked, sb.saturations);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
